// File: rtl/tcfd_pkg.sv
// package: types, constants and codes for the test command frame decoder
`timescale 1ns / 1ps
`default_nettype none

package tcfd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LED_W      = 4;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned HEAD_DEPTH = 4;
  localparam int unsigned HEAD_IDX_W = $clog2(HEAD_DEPTH);

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hEE;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h99;
  localparam logic [BYTE_W-1:0] FRAME_TAIL  = 8'hDD;

  localparam logic [BYTE_W-1:0] CMD_LED      = 8'h00;
  localparam logic [BYTE_W-1:0] CMD_BUZZER   = 8'h05;
  localparam logic [BYTE_W-1:0] CMD_LOOPBACK = 8'h07;
  localparam logic [BYTE_W-1:0] CMD_TIME_SET = 8'h09;
  localparam logic [BYTE_W-1:0] CMD_TIME_OFF = 8'h0C;
  localparam logic [BYTE_W-1:0] CMD_TEMP     = 8'h0D;
  localparam logic [BYTE_W-1:0] CMD_NET      = 8'h0E;

  localparam logic [BYTE_W-1:0] FN_OFF = 8'h00;
  localparam logic [BYTE_W-1:0] FN_ON  = 8'h01;

  // led index that aliases onto line 0
  localparam logic [BYTE_W-1:0] LED_IDX_ALIAS = 8'h04;
  localparam logic [BYTE_W-1:0] LED_LEN       = 8'h01;

  localparam logic [TIME_W-1:0] TIME_BIAS = 32'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SYNC2,
    PH_CMD,
    PH_FUNC,
    PH_LEN,
    PH_DATA,
    PH_TAIL
  } phase_t;

  typedef logic [HEAD_DEPTH-1:0][BYTE_W-1:0] head_t;

  // frame context as held by the parser before the current byte
  typedef struct packed {
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] funct;
    logic [BYTE_W-1:0] count;
    head_t             head;
  } frame_t;

  // per-byte parse outcome
  typedef struct packed {
    logic done;
    logic bad;
  } parse_evt_t;

endpackage

`default_nettype wire

// File: rtl/tcfd_parser.sv
// frame parser: header, command, function, length, payload and tail tracking
`timescale 1ns / 1ps
`default_nettype none

module tcfd_parser
  import tcfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire logic [BYTE_W-1:0] rx_byte,
  output frame_t                 frame,
  output parse_evt_t             evt
);

  phase_t            phase_r,   phase_nxt;
  logic [BYTE_W-1:0] command_r, command_nxt;
  logic [BYTE_W-1:0] funct_r,   funct_nxt;
  logic [BYTE_W-1:0] count_r,   count_nxt;
  logic [BYTE_W-1:0] taken_r,   taken_nxt;
  head_t             head_r,    head_nxt;
  logic [BYTE_W-1:0] taken_inc;

  assign taken_inc = taken_r + 8'd1;

  always_comb begin
    phase_nxt   = phase_r;
    command_nxt = command_r;
    funct_nxt   = funct_r;
    count_nxt   = count_r;
    taken_nxt   = taken_r;
    head_nxt    = head_r;
    evt         = '0;
    case (phase_r)
      PH_IDLE: begin
        if (rx_byte == SYNC_FIRST) begin
          phase_nxt = PH_SYNC2;
          head_nxt  = '0;
        end
      end
      PH_SYNC2: begin
        if (rx_byte == SYNC_SECOND) begin
          phase_nxt = PH_CMD;
        end else begin
          evt.bad = 1'b1;
          if (rx_byte == SYNC_FIRST) begin
            phase_nxt = PH_SYNC2;
            head_nxt  = '0;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_CMD: begin
        command_nxt = rx_byte;
        phase_nxt   = PH_FUNC;
      end
      PH_FUNC: begin
        funct_nxt = rx_byte;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        count_nxt = rx_byte;
        taken_nxt = '0;
        phase_nxt = (rx_byte == '0) ? PH_TAIL : PH_DATA;
      end
      PH_DATA: begin
        if (taken_r < BYTE_W'(HEAD_DEPTH)) begin
          head_nxt[taken_r[HEAD_IDX_W-1:0]] = rx_byte;
        end
        taken_nxt = taken_inc;
        if (taken_inc >= count_r) begin
          phase_nxt = PH_TAIL;
        end
      end
      PH_TAIL: begin
        if (rx_byte == FRAME_TAIL) begin
          evt.done  = 1'b1;
          phase_nxt = PH_IDLE;
        end else begin
          evt.bad = 1'b1;
          if (rx_byte == SYNC_FIRST) begin
            phase_nxt = PH_SYNC2;
            head_nxt  = '0;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      default: begin
        if (rx_byte == SYNC_FIRST) begin
          phase_nxt = PH_SYNC2;
          head_nxt  = '0;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      command_r <= '0;
      funct_r   <= '0;
      count_r   <= '0;
      taken_r   <= '0;
      head_r    <= '0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      command_r <= command_nxt;
      funct_r   <= funct_nxt;
      count_r   <= count_nxt;
      taken_r   <= taken_nxt;
      head_r    <= head_nxt;
    end
  end

  assign frame = '{command: command_r, funct: funct_r, count: count_r, head: head_r};

endmodule

`default_nettype wire

// File: rtl/tcfd_exec.sv
// command execution: done/bad flags per byte, other outputs when a frame completes
`timescale 1ns / 1ps
`default_nettype none

module tcfd_exec
  import tcfd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire frame_t             frame,
  input  wire parse_evt_t         evt,
  output logic                    frame_done,
  output logic                    frame_bad,
  output logic [BYTE_W-1:0]       command_code,
  output logic [BYTE_W-1:0]       function_code,
  output logic [LED_W-1:0]        led_lines,
  output logic                    buzzer_on,
  output logic                    loopback_mode,
  output logic                    temp_report,
  output logic                    net_check,
  output logic                    time_report,
  output logic [TIME_W-1:0]       time_value
);

  logic              done_r,  done_nxt;
  logic              bad_r,   bad_nxt;
  logic [BYTE_W-1:0] cmd_r,   cmd_nxt;
  logic [BYTE_W-1:0] fn_r,    fn_nxt;
  logic [LED_W-1:0]  led_r,   led_nxt;
  logic              buzz_r,  buzz_nxt;
  logic              loop_r,  loop_nxt;
  logic              temp_r,  temp_nxt;
  logic              net_r,   net_nxt;
  logic              tim_r,   tim_nxt;
  logic [TIME_W-1:0] secs_r,  secs_nxt;

  logic [BYTE_W-1:0] led_idx;
  logic [1:0]        led_line;
  logic              led_ok;
  logic [TIME_W-1:0] head_time;

  assign led_idx   = frame.head[0];
  assign led_ok    = (frame.count == LED_LEN) && (frame.funct <= FN_ON)
                     && (led_idx <= LED_IDX_ALIAS);
  assign led_line  = (led_idx == LED_IDX_ALIAS) ? 2'd0 : led_idx[1:0];
  assign head_time = {frame.head[0], frame.head[1], frame.head[2], frame.head[3]};

  always_comb begin
    done_nxt = evt.done;
    bad_nxt  = evt.bad;
    cmd_nxt  = cmd_r;
    fn_nxt   = fn_r;
    led_nxt  = led_r;
    buzz_nxt = buzz_r;
    loop_nxt = loop_r;
    temp_nxt = temp_r;
    net_nxt  = net_r;
    tim_nxt  = tim_r;
    secs_nxt = secs_r;
    if (evt.done) begin
      cmd_nxt = frame.command;
      fn_nxt  = frame.funct;
      case (frame.command)
        CMD_LED: begin
          if (led_ok) begin
            led_nxt[led_line] = (frame.funct == FN_ON);
          end
        end
        CMD_BUZZER: begin
          if (frame.funct == FN_OFF) begin
            buzz_nxt = 1'b0;
          end else if (frame.funct == FN_ON) begin
            buzz_nxt = 1'b1;
          end
        end
        CMD_LOOPBACK: loop_nxt = (frame.funct == FN_ON);
        CMD_TIME_SET: begin
          secs_nxt = head_time + TIME_BIAS;
          tim_nxt  = 1'b1;
        end
        CMD_TIME_OFF: tim_nxt  = 1'b0;
        CMD_TEMP:     temp_nxt = (frame.funct == FN_OFF);
        CMD_NET:      net_nxt  = (frame.funct == FN_ON);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
      bad_r  <= 1'b0;
      cmd_r  <= '0;
      fn_r   <= '0;
      led_r  <= '0;
      buzz_r <= 1'b0;
      loop_r <= 1'b0;
      temp_r <= 1'b0;
      net_r  <= 1'b0;
      tim_r  <= 1'b0;
      secs_r <= '0;
    end else if (fire) begin
      done_r <= done_nxt;
      bad_r  <= bad_nxt;
      cmd_r  <= cmd_nxt;
      fn_r   <= fn_nxt;
      led_r  <= led_nxt;
      buzz_r <= buzz_nxt;
      loop_r <= loop_nxt;
      temp_r <= temp_nxt;
      net_r  <= net_nxt;
      tim_r  <= tim_nxt;
      secs_r <= secs_nxt;
    end
  end

  assign frame_done    = done_r;
  assign frame_bad     = bad_r;
  assign command_code  = cmd_r;
  assign function_code = fn_r;
  assign led_lines     = led_r;
  assign buzzer_on     = buzz_r;
  assign loopback_mode = loop_r;
  assign temp_report   = temp_r;
  assign net_check     = net_r;
  assign time_report   = tim_r;
  assign time_value    = secs_r;

endmodule

`default_nettype wire

// File: rtl/test_command_frame_decoder_unit.sv
// top level: test command frame decoder with input and result registers
//
//  channel | ports                     | direction | transfer
//  in      | in_valid/in_ready         | in        | one received byte
//  out     | out_valid/out_ready       | out       | one result per byte
//
// one byte per cycle sustained while the result is not stalled; out_valid rises once
// the byte has passed the input register, then parse/execute into the result register.
// rst_n is synchronous and active low; it returns the parser to header hunt
// and clears all output registers.
// a stalled result holds the input register; at most one more byte is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module test_command_frame_decoder_unit
  import tcfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_rx_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_frame_done,
  output logic                   out_frame_bad,
  output logic [BYTE_W-1:0]      out_command_code,
  output logic [BYTE_W-1:0]      out_function_code,
  output logic [LED_W-1:0]       out_led_lines,
  output logic                   out_buzzer_on,
  output logic                   out_loopback_mode,
  output logic                   out_temp_report,
  output logic                   out_net_check,
  output logic                   out_time_report,
  output logic [TIME_W-1:0]      out_time_value
);

  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_vld_r;
  logic              out_adv;
  logic              fire;
  frame_t            frame;
  parse_evt_t        evt;

  assign out_adv  = !out_vld_r || out_ready;
  assign fire     = in_vld_r && out_adv;
  assign in_ready = !in_vld_r || out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (out_adv) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  tcfd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .rx_byte (in_byte_r),
    .frame   (frame),
    .evt     (evt)
  );

  tcfd_exec u_exec (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .frame         (frame),
    .evt           (evt),
    .frame_done    (out_frame_done),
    .frame_bad     (out_frame_bad),
    .command_code  (out_command_code),
    .function_code (out_function_code),
    .led_lines     (out_led_lines),
    .buzzer_on     (out_buzzer_on),
    .loopback_mode (out_loopback_mode),
    .temp_report   (out_temp_report),
    .net_check     (out_net_check),
    .time_report   (out_time_report),
    .time_value    (out_time_value)
  );

  assign out_valid = out_vld_r;

endmodule

`default_nettype wire

// File: rtl/tcfd_checker.sv
// port-level checker for the test command frame decoder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module tcfd_checker
  import tcfd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_frame_done,
  input wire logic              out_frame_bad,
  input wire logic [BYTE_W-1:0] out_command_code,
  input wire logic [LED_W-1:0]  out_led_lines,
  input wire logic              out_time_report,
  input wire logic [TIME_W-1:0] out_time_value
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_time_value)
      && $stable(out_led_lines) && $stable(out_frame_done))
    else $error("result changed while stalled");

  // a byte cannot both complete and break a frame
  a_done_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_frame_done && out_frame_bad))
    else $error("frame_done and frame_bad both set");

  // led levels only move with a completed led frame
  a_led_move: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(out_led_lines) |-> out_valid && out_frame_done
      && out_command_code == CMD_LED)
    else $error("led lines changed without a led frame");

  // time reporting only switches on by a time load frame
  a_time_on: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_time_report) |-> out_valid && out_frame_done
      && out_command_code == CMD_TIME_SET)
    else $error("time report set without a time load frame");

endmodule

bind test_command_frame_decoder_unit tcfd_checker u_tcfd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_frame_done   (out_frame_done),
  .out_frame_bad    (out_frame_bad),
  .out_command_code (out_command_code),
  .out_led_lines    (out_led_lines),
  .out_time_report  (out_time_report),
  .out_time_value   (out_time_value)
);

`default_nettype wire

// File: test/test_command_frame_decoder_unit_tb.sv
// testbench for the test command frame decoder: directed and random byte streams vs. a predictor
`timescale 1ns / 1ps

module test_command_frame_decoder_unit_tb;
  import tcfd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_WAIT    = 11;
  localparam int DRAIN_TAIL  = 8;

  typedef struct {
    logic              done;
    logic              bad;
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] funct;
    logic [LED_W-1:0]  led;
    logic              buzz;
    logic              loop;
    logic              temp;
    logic              net;
    logic              time_rep;
    logic [TIME_W-1:0] time_val;
  } status_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [BYTE_W-1:0]      in_rx_byte = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_frame_done;
  logic                   out_frame_bad;
  logic [BYTE_W-1:0]      out_command_code;
  logic [BYTE_W-1:0]      out_function_code;
  logic [LED_W-1:0]       out_led_lines;
  logic                   out_buzzer_on;
  logic                   out_loopback_mode;
  logic                   out_temp_report;
  logic                   out_net_check;
  logic                   out_time_report;
  logic [TIME_W-1:0]      out_time_value;

  test_command_frame_decoder_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_done    (out_frame_done),
    .out_frame_bad     (out_frame_bad),
    .out_command_code  (out_command_code),
    .out_function_code (out_function_code),
    .out_led_lines     (out_led_lines),
    .out_buzzer_on     (out_buzzer_on),
    .out_loopback_mode (out_loopback_mode),
    .out_temp_report   (out_temp_report),
    .out_net_check     (out_net_check),
    .out_time_report   (out_time_report),
    .out_time_value    (out_time_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder state as predicted
  phase_t            prs_phase = PH_IDLE;
  logic [BYTE_W-1:0] cur_cmd = '0;
  logic [BYTE_W-1:0] cur_fn = '0;
  logic [BYTE_W-1:0] pay_len = '0;
  logic [BYTE_W-1:0] pay_seen = '0;
  logic [BYTE_W-1:0] pay_head [HEAD_DEPTH] = '{default: '0};
  logic [BYTE_W-1:0] last_cmd = '0;
  logic [BYTE_W-1:0] last_fn = '0;
  logic [LED_W-1:0]  led_q = '0;
  logic              buzz_q = 1'b0;
  logic              loop_q = 1'b0;
  logic              temp_q = 1'b0;
  logic              net_q = 1'b0;
  logic              time_rep_q = 1'b0;
  logic [TIME_W-1:0] seconds_q = '0;

  status_t pending_status [$];
  bit      idle_on = 1'b1;
  int      bytes_sent = 0;
  int      error_count = 0;
  int      cycle_count = 0;
  int      stall_left = 0;

  task automatic restart_parse(input logic [BYTE_W-1:0] b);
    if (b == SYNC_FIRST) begin
      prs_phase = PH_SYNC2;
      for (int i = 0; i < HEAD_DEPTH; i++) pay_head[i] = '0;
    end else begin
      prs_phase = PH_IDLE;
    end
  endtask

  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    status_t s;
    s.done = 1'b0;
    s.bad  = 1'b0;
    case (prs_phase)
      PH_IDLE: restart_parse(b);
      PH_SYNC2: begin
        if (b == SYNC_SECOND) begin
          prs_phase = PH_CMD;
        end else begin
          s.bad = 1'b1;
          restart_parse(b);
        end
      end
      PH_CMD: begin
        cur_cmd   = b;
        prs_phase = PH_FUNC;
      end
      PH_FUNC: begin
        cur_fn    = b;
        prs_phase = PH_LEN;
      end
      PH_LEN: begin
        pay_len  = b;
        pay_seen = '0;
        if (b == '0) prs_phase = PH_TAIL;
        else prs_phase = PH_DATA;
      end
      PH_DATA: begin
        if (pay_seen < HEAD_DEPTH) pay_head[pay_seen[HEAD_IDX_W-1:0]] = b;
        pay_seen = pay_seen + 1'b1;
        if (pay_seen >= pay_len) prs_phase = PH_TAIL;
      end
      PH_TAIL: begin
        if (b == FRAME_TAIL) begin
          s.done   = 1'b1;
          last_cmd = cur_cmd;
          last_fn  = cur_fn;
          case (cur_cmd)
            CMD_LED: begin
              if (pay_len == LED_LEN && cur_fn <= FN_ON) begin
                // index 4 aliases onto line 0
                if (pay_head[0] == '0 || pay_head[0] == LED_IDX_ALIAS)
                  led_q[0] = (cur_fn == FN_ON);
                else if (pay_head[0] < LED_W)
                  led_q[pay_head[0][1:0]] = (cur_fn == FN_ON);
              end
            end
            CMD_BUZZER: begin
              if (cur_fn == FN_OFF) buzz_q = 1'b0;
              else if (cur_fn == FN_ON) buzz_q = 1'b1;
            end
            CMD_LOOPBACK: loop_q = (cur_fn == FN_ON);
            CMD_TIME_SET: begin
              seconds_q  = {pay_head[0], pay_head[1], pay_head[2], pay_head[3]} + TIME_BIAS;
              time_rep_q = 1'b1;
            end
            CMD_TIME_OFF: time_rep_q = 1'b0;
            CMD_TEMP:     temp_q = (cur_fn == FN_OFF);
            CMD_NET:      net_q = (cur_fn == FN_ON);
            default: ;
          endcase
          prs_phase = PH_IDLE;
        end else begin
          s.bad = 1'b1;
          restart_parse(b);
        end
      end
      default: restart_parse(b);
    endcase
    s.command  = last_cmd;
    s.funct    = last_fn;
    s.led      = led_q;
    s.buzz     = buzz_q;
    s.loop     = loop_q;
    s.temp     = temp_q;
    s.net      = net_q;
    s.time_rep = time_rep_q;
    s.time_val = seconds_q;
    pending_status.push_back(s);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] fn,
                            input logic [BYTE_W-1:0] len, input logic [31:0] head,
                            input logic [BYTE_W-1:0] tail);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(cmd);
    send_byte(fn);
    send_byte(len);
    for (int i = 0; i < len; i++)
      send_byte(i < HEAD_DEPTH ? head[31-BYTE_W*i -: BYTE_W] : BYTE_W'($urandom));
    send_byte(tail);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  task automatic test_led_control();
    send_frame(CMD_LED, FN_ON, LED_LEN, {8'd1, 24'h0}, FRAME_TAIL);
    send_frame(CMD_LED, FN_ON, LED_LEN, {8'd2, 24'h0}, FRAME_TAIL);
    send_frame(CMD_LED, FN_ON, LED_LEN, {8'd3, 24'hFFFFFF}, FRAME_TAIL);
    send_frame(CMD_LED, FN_ON, LED_LEN, {LED_IDX_ALIAS, 24'h0}, FRAME_TAIL);
    send_frame(CMD_LED, FN_OFF, LED_LEN, {8'd0, 24'h0}, FRAME_TAIL);
    send_frame(CMD_LED, FN_OFF, LED_LEN, {8'd5, 24'h0}, FRAME_TAIL);
    send_frame(CMD_LED, FN_OFF, LED_LEN, {8'hFF, 24'h0}, FRAME_TAIL);
    send_frame(CMD_LED, 8'h02, LED_LEN, {8'd2, 24'h0}, FRAME_TAIL);
    send_frame(CMD_LED, FN_OFF, 8'd2, {8'd1, 24'h0}, FRAME_TAIL);
    send_frame(CMD_LED, FN_OFF, LED_LEN, {8'd3, 24'h0}, FRAME_TAIL);
  endtask

  task automatic test_flag_commands();
    send_frame(CMD_BUZZER, FN_ON, 8'd0, '0, FRAME_TAIL);
    send_frame(CMD_BUZZER, 8'hFF, 8'd0, '0, FRAME_TAIL);
    send_frame(CMD_BUZZER, FN_OFF, 8'd1, 32'hFF00_0000, FRAME_TAIL);
    send_frame(CMD_LOOPBACK, FN_ON, 8'd0, '0, FRAME_TAIL);
    send_frame(CMD_LOOPBACK, 8'h80, 8'd0, '0, FRAME_TAIL);
    send_frame(CMD_TEMP, FN_OFF, 8'd0, '0, FRAME_TAIL);
    send_frame(CMD_TEMP, FN_ON, 8'd0, '0, FRAME_TAIL);
    send_frame(CMD_NET, FN_ON, 8'd0, '0, FRAME_TAIL);
    send_frame(CMD_NET, FN_OFF, 8'd0, '0, FRAME_TAIL);
    send_frame(8'hFF, 8'hFF, 8'd0, '0, FRAME_TAIL);
  endtask

  task automatic test_time_load();
    send_frame(CMD_TIME_SET, FN_OFF, 8'd4, 32'hFFFF_FFFF, FRAME_TAIL);
    send_frame(CMD_TIME_OFF, FN_OFF, 8'd0, '0, FRAME_TAIL);
    send_frame(CMD_TIME_SET, FN_ON, 8'd4, 32'h1234_5678, FRAME_TAIL);
    // short payload reads the missing bytes as zero
    send_frame(CMD_TIME_SET, FN_ON, 8'd2, 32'hABCD_EF01, FRAME_TAIL);
    send_frame(CMD_TIME_SET, FN_ON, 8'd6, 32'h8000_0001, FRAME_TAIL);
    send_frame(CMD_TIME_SET, FN_ON, 8'd0, 32'hFFFF_FFFF, FRAME_TAIL);
    send_frame(CMD_TIME_SET, 8'hFF, 8'hFF, 32'h7F00_FF80, FRAME_TAIL);
  endtask

  task automatic test_framing_errors();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_SECOND);
    send_byte(FRAME_TAIL);
    send_byte(SYNC_FIRST);
    send_byte(8'h00);
    // a repeated first header byte restarts the frame
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_frame(SYNC_SECOND, FN_ON, 8'd0, '0, SYNC_FIRST);
    send_frame(CMD_BUZZER, FN_ON, 8'd0, '0, 8'h55);
    send_frame(CMD_NET, FN_ON, 8'd3, 32'hDDDD_DD00, FRAME_TAIL);
  endtask

  task automatic test_random_traffic(input int n_bytes);
    int                start;
    int                kind;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] fn;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] tail;
    logic [31:0]       head;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      if ($urandom_range(0, 24) == 0) idle_on = !idle_on;
      if ($urandom_range(0, 120) == 0) wait_drained();
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 8))
        0: cmd = CMD_LED;
        1: cmd = CMD_BUZZER;
        2: cmd = CMD_LOOPBACK;
        3: cmd = CMD_TIME_SET;
        4: cmd = CMD_TIME_OFF;
        5: cmd = CMD_TEMP;
        6: cmd = CMD_NET;
        7: cmd = CMD_LED;
        default: cmd = BYTE_W'($urandom);
      endcase
      fn   = ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom) : BYTE_W'($urandom_range(0, 2));
      head = $urandom;
      if (cmd == CMD_LED) begin
        len = ($urandom_range(0, 4) == 0) ? BYTE_W'($urandom_range(0, 2)) : LED_LEN;
        head[31:24] = ($urandom_range(0, 5) == 0) ? BYTE_W'($urandom)
                                                   : BYTE_W'($urandom_range(0, 5));
      end else if ($urandom_range(0, 19) == 0) begin
        len = BYTE_W'($urandom_range(7, 40));
      end else begin
        len = BYTE_W'($urandom_range(0, 6));
      end
      if (kind < 72) begin
        send_frame(cmd, fn, len, head, FRAME_TAIL);
      end else if (kind < 82) begin
        if ($urandom_range(0, 3) == 0) begin
          tail = SYNC_FIRST;
        end else begin
          do tail = BYTE_W'($urandom); while (tail == FRAME_TAIL);
        end
        send_frame(cmd, fn, len, head, tail);
      end else if (kind < 90) begin
        send_byte(SYNC_FIRST);
        do tail = BYTE_W'($urandom); while (tail == SYNC_SECOND);
        send_byte(tail);
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    status_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_status.size() == 0) begin
          $error("result transfer with nothing expected");
          error_count++;
        end else begin
          want = pending_status.pop_front();
          check_field("frame_done", 32'(want.done), 32'(out_frame_done));
          check_field("frame_bad", 32'(want.bad), 32'(out_frame_bad));
          check_field("command_code", 32'(want.command), 32'(out_command_code));
          check_field("function_code", 32'(want.funct), 32'(out_function_code));
          check_field("led_lines", 32'(want.led), 32'(out_led_lines));
          check_field("buzzer_on", 32'(want.buzz), 32'(out_buzzer_on));
          check_field("loopback_mode", 32'(want.loop), 32'(out_loopback_mode));
          check_field("temp_report", 32'(want.temp), 32'(out_temp_report));
          check_field("net_check", 32'(want.net), 32'(out_net_check));
          check_field("time_report", 32'(want.time_rep), 32'(out_time_report));
          check_field("time_value", want.time_val, out_time_value);
        end
        stall_left = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_on = 1'b1;
    test_led_control();
    idle_on = 1'b0;
    test_flag_commands();
    wait_drained();
    idle_on = 1'b1;
    test_time_load();
    test_framing_errors();
    wait_drained();
    test_random_traffic(240);
    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/tcfd_pkg.sv
rtl/tcfd_parser.sv
rtl/tcfd_exec.sv
rtl/test_command_frame_decoder_unit.sv
rtl/tcfd_checker.sv
test/test_command_frame_decoder_unit_tb.sv
